/* sv/rrip_level_list_cache_unit_macros.svh */
// assertion macros for the rrip level list cache unit
`ifndef RRIP_LEVEL_LIST_CACHE_UNIT_MACROS_SVH
`define RRIP_LEVEL_LIST_CACHE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RLC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlc assertion failed");
`define RLC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlc assertion failed");
`else
`define RLC_ASSERT_IMP(label, ante, cons)
`define RLC_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* sv/rlc_pkg.sv */
// shared constants, types and states of the rrip level list cache
package rlc_pkg;

    localparam int CAPACITY   = 1024;
    localparam int LEVEL_BITS = 3;
    localparam int KEY_BITS   = 32;

    localparam int NUM_LEVELS = 1 << LEVEL_BITS;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int LIMIT_W    = 11;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
    localparam logic [0:0] REG_CAP_LIMIT = 1'b0;

    typedef logic [SLOT_W-1:0]     t_slot_idx;
    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [KEY_BITS-1:0]   t_key;

    localparam t_level LVL_TOP = t_level'(NUM_LEVELS - 1);
    localparam t_level LVL_NEW = t_level'(NUM_LEVELS - 2);
    localparam t_level LVL_HOT = t_level'(0);

    typedef struct packed {
        logic   valid;
        logic   pend;
        t_level lst;
        t_key   key;
    } t_slot;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_LINKRD,
        ST_UNLINK,
        ST_APPEND,
        ST_AGE,
        ST_EVRD,
        ST_NEW,
        ST_OUT
    } t_state;

endpackage

/* sv/rlc_ram.sv */
// generic single write port ram with registered read
module rlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/rrip_level_list_cache_unit.sv */
// rrip level list cache: key-only cache, eight fifo re-reference levels per slot memory.
// The unit takes no new item until the result beat of the last one is accepted:
// the key is searched by a scan of the slot memory, one entry per cycle on its single
// read port, then list unlink and relink, up to seven aging rounds before an
// eviction, and one result beat, which is held while i_stall is high.
// After reset a clearing pass runs through every entry of the slot memory, during
// which no item is accepted; the apb register stays writable all the time.
`include "rrip_level_list_cache_unit_macros.svh"
module rrip_level_list_cache_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic [31:0]                  i_key,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic                         o_evicted,
    output logic [31:0]                  o_evicted_key,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rlc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rlc_pkg::DATA_W-1:0]   pwdata,
    output logic [rlc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    localparam int SW = rlc_pkg::SLOT_W;
    localparam int EW = $bits(rlc_pkg::t_slot);

    rlc_pkg::t_state r_state, n_state;

    logic [rlc_pkg::LIMIT_W-1:0] r_limit;
    logic [SW:0]                 r_idx;
    rlc_pkg::t_level             r_base;
    rlc_pkg::t_cnt               r_occ;
    rlc_pkg::t_cnt               r_cnt  [rlc_pkg::NUM_LEVELS];
    rlc_pkg::t_slot_idx          r_head [rlc_pkg::NUM_LEVELS];
    rlc_pkg::t_slot_idx          r_tail [rlc_pkg::NUM_LEVELS];
    logic [rlc_pkg::LEVEL_BITS:0] r_age;

    logic                r_action;
    rlc_pkg::t_key       r_key;
    logic                r_found;
    rlc_pkg::t_slot_idx  r_fidx;
    logic                r_fpend;
    rlc_pkg::t_level     r_flist;
    logic                r_free_ok;
    rlc_pkg::t_slot_idx  r_free;
    logic                r_evicted;
    rlc_pkg::t_key       r_ev_key;
    rlc_pkg::t_slot_idx  r_s;
    rlc_pkg::t_level     r_pold;
    rlc_pkg::t_level     r_dst;
    logic                r_is_ev;

    // slot memory and link memories
    logic               main_we;
    rlc_pkg::t_slot_idx main_waddr, main_raddr;
    rlc_pkg::t_slot     main_wdata, slot_rd;
    logic [EW-1:0]      main_rdata;
    logic               nxt_we, prv_we;
    rlc_pkg::t_slot_idx nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
    rlc_pkg::t_slot_idx nxt_rd, prv_rd;

    rlc_ram #(.WIDTH(EW), .DEPTH(rlc_pkg::CAPACITY)) u_slot_ram (
        .i_clk(i_clk), .i_we(main_we), .i_waddr(main_waddr), .i_wdata(main_wdata),
        .i_raddr(main_raddr), .o_rdata(main_rdata)
    );
    rlc_ram #(.WIDTH(SW), .DEPTH(rlc_pkg::CAPACITY)) u_next_ram (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(r_s), .o_rdata(nxt_rd)
    );
    rlc_ram #(.WIDTH(SW), .DEPTH(rlc_pkg::CAPACITY)) u_prev_ram (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_waddr), .i_wdata(prv_wdata),
        .i_raddr(r_s), .o_rdata(prv_rd)
    );

    assign slot_rd = rlc_pkg::t_slot'(main_rdata);

    // derived values
    logic                         in_acc, out_acc, cfg_wr;
    rlc_pkg::t_level              phys_top, phys_new, phys_hot;
    rlc_pkg::t_cnt                eff_limit;
    logic                         need_evict;
    logic                         scan_hit, scan_free;
    rlc_pkg::t_slot_idx           scan_slot;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign cfg_wr  = psel && penable && pwrite && pready &&
                     (paddr[rlc_pkg::ADDR_W-1:2] == rlc_pkg::REG_CAP_LIMIT);

    assign phys_top = rlc_pkg::t_level'(rlc_pkg::LVL_TOP - r_base);
    assign phys_new = rlc_pkg::t_level'(rlc_pkg::LVL_NEW - r_base);
    assign phys_hot = rlc_pkg::t_level'(rlc_pkg::LVL_HOT - r_base);

    assign eff_limit = (r_limit > rlc_pkg::LIMIT_W'(rlc_pkg::CAPACITY)) ?
                       rlc_pkg::CNT_W'(rlc_pkg::CAPACITY) : rlc_pkg::CNT_W'(r_limit);
    assign need_evict = (r_occ >= eff_limit) && (r_occ != '0);

    assign scan_slot = rlc_pkg::t_slot_idx'(r_idx - 1'b1);
    assign scan_hit  = (r_idx != '0) && slot_rd.valid && (slot_rd.key == r_key);
    assign scan_free = (r_idx != '0) && !slot_rd.valid && !r_free_ok;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlc_pkg::ST_CLEAR: begin
                if (r_idx == (SW+1)'(rlc_pkg::CAPACITY - 1)) n_state = rlc_pkg::ST_IDLE;
            end
            rlc_pkg::ST_IDLE: begin
                if (i_valid) n_state = rlc_pkg::ST_SCAN;
            end
            rlc_pkg::ST_SCAN: begin
                if (r_idx == (SW+1)'(rlc_pkg::CAPACITY)) n_state = rlc_pkg::ST_DECIDE;
            end
            rlc_pkg::ST_DECIDE: begin
                if (r_found) begin
                    n_state = (r_action && r_fpend) ? rlc_pkg::ST_LINKRD : rlc_pkg::ST_OUT;
                end else if (r_action) begin
                    n_state = need_evict ? rlc_pkg::ST_AGE : rlc_pkg::ST_NEW;
                end else begin
                    n_state = rlc_pkg::ST_OUT;
                end
            end
            rlc_pkg::ST_LINKRD: n_state = rlc_pkg::ST_UNLINK;
            rlc_pkg::ST_UNLINK: n_state = r_is_ev ? rlc_pkg::ST_NEW : rlc_pkg::ST_APPEND;
            rlc_pkg::ST_APPEND: n_state = rlc_pkg::ST_OUT;
            rlc_pkg::ST_AGE: begin
                if (r_cnt[phys_top] != '0) begin
                    n_state = rlc_pkg::ST_EVRD;
                end else if (r_age == (rlc_pkg::LEVEL_BITS+1)'(rlc_pkg::NUM_LEVELS)) begin
                    n_state = rlc_pkg::ST_NEW;
                end
            end
            rlc_pkg::ST_EVRD: n_state = rlc_pkg::ST_UNLINK;
            rlc_pkg::ST_NEW: n_state = r_free_ok ? rlc_pkg::ST_APPEND : rlc_pkg::ST_OUT;
            rlc_pkg::ST_OUT: begin
                if (!i_stall) n_state = rlc_pkg::ST_IDLE;
            end
            default: n_state = rlc_pkg::ST_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        main_we    = 1'b0;
        main_waddr = r_s;
        main_wdata = '0;
        main_raddr = (r_state == rlc_pkg::ST_SCAN) ? r_idx[SW-1:0] : r_s;
        nxt_we     = 1'b0;
        nxt_waddr  = prv_rd;
        nxt_wdata  = nxt_rd;
        prv_we     = 1'b0;
        prv_waddr  = nxt_rd;
        prv_wdata  = prv_rd;
        unique case (r_state)
            rlc_pkg::ST_CLEAR: begin
                main_we    = 1'b1;
                main_waddr = r_idx[SW-1:0];
            end
            rlc_pkg::ST_DECIDE: begin
                main_waddr = r_fidx;
                main_wdata = '{valid: 1'b1, pend: !r_action, lst: r_flist, key: r_key};
                if (r_found && !r_action) begin
                    main_we = 1'b1;
                end else if (r_found && r_fpend) begin
                    main_we        = 1'b1;
                    main_wdata.lst = phys_hot;
                end
            end
            rlc_pkg::ST_UNLINK: begin
                main_we = r_is_ev;
                nxt_we  = (r_head[r_pold] != r_s);
                prv_we  = (r_tail[r_pold] != r_s);
            end
            rlc_pkg::ST_NEW: begin
                main_we    = r_free_ok;
                main_waddr = r_free;
                main_wdata = '{valid: 1'b1, pend: 1'b0, lst: phys_new, key: r_key};
            end
            rlc_pkg::ST_APPEND: begin
                nxt_we    = (r_cnt[r_dst] != '0);
                nxt_waddr = r_tail[r_dst];
                nxt_wdata = r_s;
                prv_we    = (r_cnt[r_dst] != '0);
                prv_waddr = r_s;
                prv_wdata = r_tail[r_dst];
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlc_pkg::ST_CLEAR;
            r_limit <= rlc_pkg::LIMIT_RESET;
            r_idx   <= '0;
            r_base  <= '0;
            r_occ   <= '0;
            r_age   <= '0;
            for (int i = 0; i < rlc_pkg::NUM_LEVELS; i++) r_cnt[i] <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) r_limit <= pwdata[rlc_pkg::LIMIT_W-1:0];
            case (r_state)
                rlc_pkg::ST_CLEAR: r_idx <= r_idx + 1'b1;
                rlc_pkg::ST_IDLE: begin
                    r_idx <= '0;
                    r_age <= '0;
                end
                rlc_pkg::ST_SCAN: r_idx <= r_idx + 1'b1;
                rlc_pkg::ST_AGE: begin
                    if (r_cnt[phys_top] == '0 &&
                        r_age != (rlc_pkg::LEVEL_BITS+1)'(rlc_pkg::NUM_LEVELS)) begin
                        r_base <= r_base + 1'b1;
                        r_age  <= r_age + 1'b1;
                    end
                end
                rlc_pkg::ST_UNLINK: begin
                    if (r_cnt[r_pold] != '0) r_cnt[r_pold] <= r_cnt[r_pold] - 1'b1;
                    if (r_is_ev) r_occ <= r_occ - 1'b1;
                end
                rlc_pkg::ST_NEW: begin
                    if (r_free_ok) r_occ <= r_occ + 1'b1;
                end
                rlc_pkg::ST_APPEND: r_cnt[r_dst] <= r_cnt[r_dst] + 1'b1;
                default: begin
                end
            endcase
        end
    end

    // item and list payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            rlc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_action  <= i_action;
                    r_key     <= i_key;
                    r_found   <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_evicted <= 1'b0;
                    r_ev_key  <= '0;
                end
            end
            rlc_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    r_found <= 1'b1;
                    r_fidx  <= scan_slot;
                    r_fpend <= slot_rd.pend;
                    r_flist <= slot_rd.lst;
                end
                if (scan_free) begin
                    r_free_ok <= 1'b1;
                    r_free    <= scan_slot;
                end
            end
            rlc_pkg::ST_DECIDE: begin
                r_s     <= r_fidx;
                r_pold  <= r_flist;
                r_dst   <= phys_hot;
                r_is_ev <= 1'b0;
            end
            rlc_pkg::ST_AGE: begin
                r_s     <= r_head[phys_top];
                r_pold  <= phys_top;
                r_is_ev <= 1'b1;
            end
            rlc_pkg::ST_UNLINK: begin
                if (r_head[r_pold] == r_s) r_head[r_pold] <= nxt_rd;
                if (r_tail[r_pold] == r_s) r_tail[r_pold] <= prv_rd;
                if (r_is_ev) begin
                    r_evicted <= 1'b1;
                    r_ev_key  <= slot_rd.key;
                    if (!r_free_ok || r_s < r_free) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_s;
                    end
                end
            end
            rlc_pkg::ST_NEW: begin
                r_s   <= r_free;
                r_dst <= phys_new;
            end
            rlc_pkg::ST_APPEND: begin
                if (r_cnt[r_dst] == '0) r_head[r_dst] <= r_s;
                r_tail[r_dst] <= r_s;
            end
            default: begin
            end
        endcase
    end

    // handshake and result
    always_comb begin
        o_stall       = (r_state != rlc_pkg::ST_IDLE);
        o_valid       = (r_state == rlc_pkg::ST_OUT);
        o_hit         = r_found;
        o_evicted     = r_evicted;
        o_evicted_key = r_ev_key;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[rlc_pkg::ADDR_W-1:2] == rlc_pkg::REG_CAP_LIMIT) ?
                    rlc_pkg::DATA_W'(r_limit) : '0;

    `RLC_ASSERT_IMP(a_occ_bound, 1'b1, r_occ <= rlc_pkg::CNT_W'(rlc_pkg::CAPACITY))
    `RLC_ASSERT_IMP(a_ev_key_zero, o_valid && !o_evicted, o_evicted_key == '0)
    `RLC_ASSERT_IMP(a_ev_only_miss, o_valid && o_evicted, !o_hit && r_action)
    `RLC_ASSERT_NXT(a_accept_scan, in_acc, r_state == rlc_pkg::ST_SCAN && r_idx == '0)
endmodule
